/* hdl/cc20_pkg.sv */
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher package
// Shared constants, types and the block-function helpers.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int BLOCK_BYTES     = 64;
    localparam int BLOCK_W         = 512;
    localparam int LEFT_W          = 7;
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;
    localparam logic [31:0] TAU_1   = 32'h3120646e;
    localparam logic [31:0] TAU_2   = 32'h79622d36;

    typedef logic [15:0][31:0] words_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_WORD_0,
        CFG_KEY_WORD_1,
        CFG_KEY_WORD_2,
        CFG_KEY_WORD_3,
        CFG_SHORT_KEY_MODE,
        CFG_NONCE_LOW,
        CFG_NONCE_HIGH,
        CFG_COUNTER_START
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_ADD,
        CORE_DONE
    } core_state_t;

    typedef struct packed {
        logic [63:0] key_word_0;
        logic [63:0] key_word_1;
        logic [63:0] key_word_2;
        logic [63:0] key_word_3;
        logic        short_key_mode;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [31:0] counter_start;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        words_t block;
    } core_res_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        return (v << n) | (v >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic words_t init_matrix(input cfg_t c, input logic [31:0] ctr);
        words_t      w;
        logic [63:0] hi_a;
        logic [63:0] hi_b;
        hi_a  = c.short_key_mode ? c.key_word_0 : c.key_word_2;
        hi_b  = c.short_key_mode ? c.key_word_1 : c.key_word_3;
        w[0]  = SIGMA_0;
        w[1]  = c.short_key_mode ? TAU_1 : SIGMA_1;
        w[2]  = c.short_key_mode ? TAU_2 : SIGMA_2;
        w[3]  = SIGMA_3;
        w[4]  = c.key_word_0[31:0];
        w[5]  = c.key_word_0[63:32];
        w[6]  = c.key_word_1[31:0];
        w[7]  = c.key_word_1[63:32];
        w[8]  = hi_a[31:0];
        w[9]  = hi_a[63:32];
        w[10] = hi_b[31:0];
        w[11] = hi_b[63:32];
        w[12] = ctr;
        w[13] = c.nonce_low[31:0];
        w[14] = c.nonce_low[63:32];
        w[15] = c.nonce_high;
        return w;
    endfunction

    // Half of a column or diagonal round: four independent quarters.
    function automatic words_t half_round(input words_t w, input logic diag,
                                          input logic second);
        words_t      r;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        r = w;
        for (int q = 0; q < 4; q++) begin
            ia = 4'(q);
            ib = diag ? 4'(4 + ((q + 1) & 3))  : 4'(4 + q);
            ic = diag ? 4'(8 + ((q + 2) & 3))  : 4'(8 + q);
            id = diag ? 4'(12 + ((q + 3) & 3)) : 4'(12 + q);
            a  = r[ia];
            b  = r[ib];
            c  = r[ic];
            d  = r[id];
            a  = a + b;
            d  = rotl32(d ^ a, second ? 5'd8 : 5'd16);
            c  = c + d;
            b  = rotl32(b ^ c, second ? 5'd7 : 5'd12);
            r[ia] = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        return r;
    endfunction

endpackage

/* hdl/cc20_front.sv */
// ----------------------------------------------------------------------------
// ChaCha20 input queue
// Accepts message bytes and queues them for the keystream combiner.
// ----------------------------------------------------------------------------
module cc20_front (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_in,
    output logic       q_valid,
    output logic [7:0] q_data,
    input  logic       q_pop
);

    logic [7:0]                   mem [cc20_pkg::FIFO_DEPTH];
    logic [cc20_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [cc20_pkg::PTR_W-1:0]   wr_ptr_next;
    logic [cc20_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [cc20_pkg::PTR_W-1:0]   rd_ptr_next;
    logic [cc20_pkg::PTR_W:0]     count_reg;
    logic [cc20_pkg::PTR_W:0]     count_next;
    logic                         push;
    logic                         pop;

    assign s_ready = (count_reg != (cc20_pkg::PTR_W+1)'(cc20_pkg::FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (cc20_pkg::PTR_W+1)'(push)
                    - (cc20_pkg::PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/cc20_core.sv */
// ----------------------------------------------------------------------------
// ChaCha20 block engine
// Iterative block function, two half-round steps per round,
// feed-forward addition, then holds the block until it is taken.
// ----------------------------------------------------------------------------
module cc20_core #(
    parameter int ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cc20_pkg::cfg_t      cfg,
    input  logic                flush,
    input  logic                take,
    output cc20_pkg::core_res_t res
);

    localparam int STEP_W = $clog2(2 * ROUND_COUNT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ROUND_COUNT - 1);

    cc20_pkg::core_state_t state_reg;
    cc20_pkg::core_state_t state_next;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [31:0]           cnt_reg;
    logic [31:0]           cnt_next;
    logic [31:0]           cur_cnt_reg;
    logic [31:0]           cur_cnt_next;
    cc20_pkg::words_t      work_reg;
    cc20_pkg::words_t      work_next;
    cc20_pkg::words_t      init_w;
    logic [31:0]           ctr_sel;

    assign ctr_sel   = (state_reg == cc20_pkg::CORE_IDLE) ? cnt_reg : cur_cnt_reg;
    assign init_w    = cc20_pkg::init_matrix(cfg, ctr_sel);
    assign res.valid = (state_reg == cc20_pkg::CORE_DONE);
    assign res.block = work_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        cur_cnt_next = cur_cnt_reg;
        work_next    = work_reg;
        case (state_reg)
            cc20_pkg::CORE_IDLE: begin
                work_next    = init_w;
                cur_cnt_next = cnt_reg;
                cnt_next     = cnt_reg + 32'd1;
                step_next    = '0;
                state_next   = cc20_pkg::CORE_RUN;
            end
            cc20_pkg::CORE_RUN: begin
                work_next = cc20_pkg::half_round(work_reg, step_reg[1], step_reg[0]);
                if (step_reg == LAST_STEP) begin
                    state_next = cc20_pkg::CORE_ADD;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            cc20_pkg::CORE_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    work_next[i] = work_reg[i] + init_w[i];
                end
                state_next = cc20_pkg::CORE_DONE;
            end
            cc20_pkg::CORE_DONE: begin
                if (take) begin
                    state_next = cc20_pkg::CORE_IDLE;
                end
            end
            default: begin
                state_next = cc20_pkg::CORE_IDLE;
            end
        endcase
        if (flush) begin
            state_next = cc20_pkg::CORE_IDLE;
            cnt_next   = cfg.counter_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cc20_pkg::CORE_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_cnt_reg <= cur_cnt_next;
        work_reg    <= work_next;
    end

endmodule

/* hdl/cc20_back.sv */
// ----------------------------------------------------------------------------
// ChaCha20 keystream combiner
// Holds the current keystream block, XORs queued bytes with it and
// registers the result for the output channel.
// ----------------------------------------------------------------------------
module cc20_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                flush,
    input  logic                q_valid,
    input  logic [7:0]          q_data,
    output logic                q_pop,
    input  cc20_pkg::core_res_t core_res,
    output logic                take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_data_out
);

    logic [cc20_pkg::BLOCK_W-1:0] ks_reg;
    logic [cc20_pkg::BLOCK_W-1:0] ks_next;
    logic [cc20_pkg::LEFT_W-1:0]  left_reg;
    logic [cc20_pkg::LEFT_W-1:0]  left_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [7:0]                   m_data_reg;
    logic [7:0]                   m_data_next;
    logic                         out_free;
    logic                         fire;

    assign out_free   = !m_valid_reg || m_ready;
    assign fire       = q_valid && (left_reg != '0) && out_free && !flush;
    assign take       = core_res.valid && !flush
                      && ((left_reg == '0) || (fire && left_reg == cc20_pkg::LEFT_W'(1)));
    assign q_pop      = fire;
    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;

    always_comb begin
        ks_next      = ks_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_data_next  = q_data ^ ks_reg[7:0];
            ks_next      = ks_reg >> 8;
            left_next    = left_reg - 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            ks_next   = core_res.block;
            left_next = cc20_pkg::LEFT_W'(cc20_pkg::BLOCK_BYTES);
        end
        if (flush) begin
            left_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ks_reg     <= ks_next;
        m_data_reg <= m_data_next;
    end

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= cc20_pkg::LEFT_W'(cc20_pkg::BLOCK_BYTES))
        else $error("keystream byte count out of range");

    a_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        core_res.valid && left_reg == '0 && !flush |=>
            left_reg == cc20_pkg::LEFT_W'(cc20_pkg::BLOCK_BYTES))
        else $error("ready block not loaded into empty keystream buffer");

    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && left_reg != '0 && !m_valid_reg && !flush |=> m_valid_reg)
        else $error("queued byte with keystream available not transferred");

    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        flush |=> left_reg == '0 && !$past(take))
        else $error("keystream kept or block taken across a flush");

endmodule

/* hdl/chacha20_stream_cipher_core.sv */
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core
// One message byte in, one byte XORed with the ChaCha20 keystream out.
// ----------------------------------------------------------------------------
// Sustained rate is one byte per clock while input is offered and the output
// is not stalled. The block engine loads the state, runs two half-round steps
// per round (four quarter-rounds side by side) and adds the feed-forward for a
// 64-byte block, and works on the next block while the current one is consumed,
// so it keeps ahead of the byte stream. Each byte passes through the input
// queue and the output register. After reset or any configuration write the
// first byte waits for a fresh block. Every configuration write reloads the
// block counter from counter_start and drops the keystream held.
module chacha20_stream_cipher_core #(
    parameter int ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_data_out
);

    cc20_pkg::cfg_t      cfg_reg;
    cc20_pkg::cfg_t      cfg_next;
    logic                flush_reg;
    logic                q_valid;
    logic [7:0]          q_data;
    logic                q_pop;
    logic                take;
    cc20_pkg::core_res_t core_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cc20_pkg::cfg_idx_t'(cfg_index))
                cc20_pkg::CFG_KEY_WORD_0:     cfg_next.key_word_0     = cfg_wdata;
                cc20_pkg::CFG_KEY_WORD_1:     cfg_next.key_word_1     = cfg_wdata;
                cc20_pkg::CFG_KEY_WORD_2:     cfg_next.key_word_2     = cfg_wdata;
                cc20_pkg::CFG_KEY_WORD_3:     cfg_next.key_word_3     = cfg_wdata;
                cc20_pkg::CFG_SHORT_KEY_MODE: cfg_next.short_key_mode = cfg_wdata[0];
                cc20_pkg::CFG_NONCE_LOW:      cfg_next.nonce_low      = cfg_wdata;
                cc20_pkg::CFG_NONCE_HIGH:     cfg_next.nonce_high     = cfg_wdata[31:0];
                cc20_pkg::CFG_COUNTER_START:  cfg_next.counter_start  = cfg_wdata[31:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg   <= '0;
            flush_reg <= 1'b0;
        end else begin
            cfg_reg   <= cfg_next;
            flush_reg <= cfg_we;
        end
    end

    cc20_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data_in (s_data_in),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    cc20_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .flush   (flush_reg),
        .take    (take),
        .res     (core_res)
    );

    cc20_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (flush_reg),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .core_res   (core_res),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_out (m_data_out)
    );

endmodule

/* verif/chacha20_stream_cipher_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core testbench
// Drives message bytes through the core under several key, nonce and counter
// settings, including the all-zero reset setting, the 128-bit key mode and a
// counter wrap. The expected ciphertext is worked out in the tracker below
// and checked in order against every output transfer. Random gaps on both
// channels and one long output stall put back-pressure on the core.
// ----------------------------------------------------------------------------

class keystream_tracker;
    logic [63:0] key_words[4];
    logic        short_key;
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] ctr_start;
    logic [31:0] block_words[16];
    logic [31:0] mix[16];
    logic [31:0] blk_ctr;
    int unsigned left;
    logic [7:0]  cipher_q[$];
    int unsigned errors;
    int unsigned refills;
    int unsigned checked;

    function new();
        foreach (key_words[i]) key_words[i] = '0;
        foreach (block_words[i]) block_words[i] = '0;
        short_key = 1'b0;
        nonce_lo  = '0;
        nonce_hi  = '0;
        ctr_start = '0;
        blk_ctr   = '0;
        left      = 0;
        errors    = 0;
        refills   = 0;
        checked   = 0;
    endfunction

    function logic [31:0] rotate_left(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter_round(int a, int b, int c, int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rotate_left(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rotate_left(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rotate_left(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rotate_left(mix[b] ^ mix[c], 7);
    endfunction

    function void next_keystream_block();
        logic [31:0] init[16];
        logic [63:0] hi_a;
        logic [63:0] hi_b;
        hi_a = short_key ? key_words[0] : key_words[2];
        hi_b = short_key ? key_words[1] : key_words[3];
        // "expand 32-byte k" or "expand 16-byte k"
        init[0]  = 32'h61707865;
        init[1]  = short_key ? 32'h3120646e : 32'h3320646e;
        init[2]  = short_key ? 32'h79622d36 : 32'h79622d32;
        init[3]  = 32'h6b206574;
        init[4]  = key_words[0][31:0];
        init[5]  = key_words[0][63:32];
        init[6]  = key_words[1][31:0];
        init[7]  = key_words[1][63:32];
        init[8]  = hi_a[31:0];
        init[9]  = hi_a[63:32];
        init[10] = hi_b[31:0];
        init[11] = hi_b[63:32];
        init[12] = blk_ctr;
        init[13] = nonce_lo[31:0];
        init[14] = nonce_lo[63:32];
        init[15] = nonce_hi;
        foreach (mix[i]) mix[i] = init[i];
        for (int r = 0; r < cc20_pkg::ROUND_COUNT_DEF; r++) begin
            if ((r % 2) == 0) begin
                quarter_round(0, 4, 8, 12);
                quarter_round(1, 5, 9, 13);
                quarter_round(2, 6, 10, 14);
                quarter_round(3, 7, 11, 15);
            end else begin
                quarter_round(0, 5, 10, 15);
                quarter_round(1, 6, 11, 12);
                quarter_round(2, 7, 8, 13);
                quarter_round(3, 4, 9, 14);
            end
        end
        foreach (block_words[i]) block_words[i] = mix[i] + init[i];
        blk_ctr = blk_ctr + 32'd1;
        left    = 64;
        refills++;
    endfunction

    function void load_register(cc20_pkg::cfg_idx_t idx, logic [63:0] val);
        case (idx)
            cc20_pkg::CFG_KEY_WORD_0:     key_words[0] = val;
            cc20_pkg::CFG_KEY_WORD_1:     key_words[1] = val;
            cc20_pkg::CFG_KEY_WORD_2:     key_words[2] = val;
            cc20_pkg::CFG_KEY_WORD_3:     key_words[3] = val;
            cc20_pkg::CFG_SHORT_KEY_MODE: short_key    = val[0];
            cc20_pkg::CFG_NONCE_LOW:      nonce_lo     = val;
            cc20_pkg::CFG_NONCE_HIGH:     nonce_hi     = val[31:0];
            cc20_pkg::CFG_COUNTER_START:  ctr_start    = val[31:0];
            default: ;
        endcase
        blk_ctr = ctr_start;
        left    = 0;
    endfunction

    function void take_plaintext(logic [7:0] b);
        int unsigned pos;
        logic [31:0] w;
        if (left == 0) next_keystream_block();
        pos = 64 - left;
        w   = block_words[pos / 4] >> ((pos % 4) * 8);
        left--;
        cipher_q.push_back(b ^ w[7:0]);
    endfunction

    function void match_cipher_byte(logic [7:0] got);
        logic [7:0] want;
        if (cipher_q.size() == 0) begin
            errors++;
            $error("data_out: expected none, actual %02h", got);
            return;
        end
        want = cipher_q.pop_front();
        checked++;
        if (got !== want) begin
            errors++;
            $error("data_out: expected %02h, actual %02h", want, got);
        end
    endfunction

    function int pending();
        return cipher_q.size();
    endfunction
endclass

module chacha20_stream_cipher_core_tb;

    localparam int TOTAL_BYTES = 1050;
    localparam int QUIET_FROM  = 850;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                            aclk       = 1'b0;
    logic                            aresetn    = 1'b0;
    logic                            cfg_we     = 1'b0;
    logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                            s_valid    = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_data_in  = '0;
    logic                            m_valid;
    logic                            m_ready    = 1'b0;
    logic [7:0]                      m_data_out;

    keystream_tracker sb;
    bit          tx_gaps      = 1'b1;
    bit          rx_gaps      = 1'b1;
    bit          hold_request = 1'b0;
    int          stall_left   = 0;
    int unsigned cycles       = 0;
    int unsigned sent         = 0;
    int unsigned settings     = 1;

    chacha20_stream_cipher_core #(
        .ROUND_COUNT(cc20_pkg::ROUND_COUNT_DEF)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data_in (s_data_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data_out(m_data_out)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: random stall bursts, plus one long hold on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_gaps && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.match_cipher_byte(m_data_out);
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data_in <= b;
        do @(posedge aclk); while (!s_ready);
        sb.take_plaintext(b);
        sent++;
    endtask

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic run_bytes(input int n);
        for (int i = 0; i < n; i++) begin
            if (tx_gaps && $urandom_range(0, 9) == 0) idle_input($urandom_range(1, 17));
            send_byte(8'($urandom));
        end
    endtask

    // wait until every expected byte is back before touching registers
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cc20_pkg::cfg_idx_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.load_register(idx, val);
    endtask

    task automatic close_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_all(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] mode, input logic [63:0] nlo,
                            input logic [63:0] nhi, input logic [63:0] cstart);
        write_reg(cc20_pkg::CFG_KEY_WORD_0, k0);
        write_reg(cc20_pkg::CFG_KEY_WORD_1, k1);
        write_reg(cc20_pkg::CFG_KEY_WORD_2, k2);
        write_reg(cc20_pkg::CFG_KEY_WORD_3, k3);
        write_reg(cc20_pkg::CFG_SHORT_KEY_MODE, mode);
        write_reg(cc20_pkg::CFG_NONCE_LOW, nlo);
        write_reg(cc20_pkg::CFG_NONCE_HIGH, nhi);
        write_reg(cc20_pkg::CFG_COUNTER_START, cstart);
        close_writes();
        settings++;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        bit any;
        int batch;
        logic [7:0] edge_bytes[12];
        edge_bytes = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h01, 8'h80, 8'h7f, 8'hfe,
                       8'h0f, 8'hf0, 8'h00, 8'hff};
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: all-zero key and nonce, counter zero
        foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
        run_bytes(8);
        settle();

        // 256-bit key, byte-sequence key, counter 1
        load_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                 64'h0, 64'h4a00000009000000, 64'h0, 64'h1);
        run_bytes(130);
        settle();

        // all-ones setting, counter at its top so it wraps; wide values truncated
        load_all('1, '1, '1, '1, 64'hffff_ffff_ffff_fffe, '1,
                 64'hdead_beef_ffff_ffff, 64'h1234_5678_ffff_ffff);
        run_bytes(150);
        settle();

        // 128-bit key mode with a long output stall to fill the core
        load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, '1, {$urandom, $urandom}, {32'h0, $urandom},
                 64'h0);
        hold_request = 1'b1;
        run_bytes(200);
        settle();

        while (sent < TOTAL_BYTES) begin
            if (sent >= QUIET_FROM) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            any = 1'b0;
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    if (i == int'(cc20_pkg::CFG_SHORT_KEY_MODE))
                        write_reg(cc20_pkg::CFG_SHORT_KEY_MODE, {$urandom, $urandom});
                    else
                        write_reg(cc20_pkg::cfg_idx_t'(i), pick_word());
                    any = 1'b1;
                end
            end
            if (!any) write_reg(cc20_pkg::CFG_COUNTER_START, pick_word());
            close_writes();
            settings++;
            batch = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 20))
                                                : int'($urandom_range(40, 140));
            if (batch > int'(TOTAL_BYTES - sent)) batch = int'(TOTAL_BYTES - sent);
            run_bytes(batch);
            settle();
        end

        repeat (20) @(posedge aclk);
        sb.errors += sb.pending();
        $display("Sent %0d bytes under %0d register settings, %0d bytes checked,",
                 sent, settings, sb.checked);
        $display("%0d keystream blocks incl. counter wrap and both key lengths.",
                 sb.refills);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
